// ===== hdl/mvca_pkg.sv =====
package mvca_pkg;

  // result width of one corner area
  localparam int AREA_BITS = 42;
  // quotient width ahead of the square root (twice the root width)
  localparam int QUO_BITS = 2 * AREA_BITS;
  // output beat width, three areas rounded up to whole bytes
  localparam int OUT_W = ((3 * AREA_BITS + 7) / 8) * 8;

  // divisors of q * 2^(2f) in the obtuse case: obtuse corner, other corners
  localparam int OBT_DIV  = 16;
  localparam int SIDE_DIV = 64;
  // acute case divides by 64 * q
  localparam int ACUTE_SHIFT = 6;

  typedef struct packed {
    logic degenerate;
    logic obtuse;
  } flags_t;

endpackage

// ===== hdl/mvca_geom.sv =====
module mvca_geom #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 8,
  parameter int NUM_W      = 154,
  parameter int DEN_W      = 74
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   en,
  input  logic                                   in_vld,
  input  logic [8:0][COORD_BITS-1:0]             coord,
  output logic                                   out_vld,
  output mvca_pkg::flags_t                       out_flags,
  output logic [2:0][NUM_W-1:0]                  num,
  output logic [2:0][DEN_W-1:0]                  den
);

  localparam int DW   = COORD_BITS + 1;
  localparam int XW   = 2 * COORD_BITS + 2;
  localparam int DTW  = 2 * COORD_BITS + 3;
  localparam int LW   = 2 * COORD_BITS + 2;
  localparam int SQW  = 4 * COORD_BITS + 2;
  localparam int QW   = 4 * COORD_BITS + 4;
  localparam int NW   = 4 * COORD_BITS + 5;
  localparam int HW   = (NW + 1) / 2;
  localparam int HHW  = NW - HW;
  localparam int N2W  = 2 * NW;

  // stage 1: edge vectors
  logic                       v1;
  logic signed [2:0][DW-1:0]  ab, ac, bc;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_vld;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ab[i] <= DW'($signed(coord[3+i])) - DW'($signed(coord[i]));
        ac[i] <= DW'($signed(coord[6+i])) - DW'($signed(coord[i]));
        bc[i] <= DW'($signed(coord[6+i])) - DW'($signed(coord[3+i]));
      end
    end
  end

  // stage 2: cross product, corner dots, squared edges
  logic                        v2;
  logic signed [XW-1:0]        cr [3];
  logic signed [DTW-1:0]       dt [3];
  logic [LW-1:0]               lab, lbc, lca;
  logic signed [DTW-1:0]       sab, sbc, sca;
  logic signed [DTW-1:0]       dabbc;

  always_comb begin
    sab = $signed(ab[0]) * $signed(ab[0]) + $signed(ab[1]) * $signed(ab[1])
        + $signed(ab[2]) * $signed(ab[2]);
    sbc = $signed(bc[0]) * $signed(bc[0]) + $signed(bc[1]) * $signed(bc[1])
        + $signed(bc[2]) * $signed(bc[2]);
    sca = $signed(ac[0]) * $signed(ac[0]) + $signed(ac[1]) * $signed(ac[1])
        + $signed(ac[2]) * $signed(ac[2]);
    dabbc = $signed(ab[0]) * $signed(bc[0]) + $signed(ab[1]) * $signed(bc[1])
          + $signed(ab[2]) * $signed(bc[2]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      cr[0] <= $signed(ab[1]) * $signed(ac[2]) - $signed(ab[2]) * $signed(ac[1]);
      cr[1] <= $signed(ab[2]) * $signed(ac[0]) - $signed(ab[0]) * $signed(ac[2]);
      cr[2] <= $signed(ab[0]) * $signed(ac[1]) - $signed(ab[1]) * $signed(ac[0]);
      dt[0] <= $signed(ab[0]) * $signed(ac[0]) + $signed(ab[1]) * $signed(ac[1])
             + $signed(ab[2]) * $signed(ac[2]);
      dt[1] <= -dabbc;
      dt[2] <= $signed(ac[0]) * $signed(bc[0]) + $signed(ac[1]) * $signed(bc[1])
             + $signed(ac[2]) * $signed(bc[2]);
      lab <= sab[LW-1:0];
      lbc <= sbc[LW-1:0];
      lca <= sca[LW-1:0];
    end
  end

  // stage 3: squared cross terms and cotangent numerators
  logic                  v3;
  logic [SQW-1:0]        sq [3];
  logic [NW-1:0]         nn [3];
  logic [2:0]            obt3;
  logic signed [2*XW-1:0] sqf [3];
  logic [2*LW-1:0]       pr_ab2, pr_ca1, pr_bc0;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sqf[i] = cr[i] * cr[i];
    end
    pr_ab2 = lab * dt[2][LW-1:0];
    pr_ca1 = lca * dt[1][LW-1:0];
    pr_bc0 = lbc * dt[0][LW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq[i]   <= sqf[i][SQW-1:0];
        obt3[i] <= dt[i][DTW-1];
      end
      nn[0] <= NW'(pr_ab2) + NW'(pr_ca1);
      nn[1] <= NW'(pr_ab2) + NW'(pr_bc0);
      nn[2] <= NW'(pr_ca1) + NW'(pr_bc0);
    end
  end

  // stage 4: doubled area squared, numerator squared in partial products
  logic                   v4;
  logic [QW-1:0]          q4;
  logic [2:0]             obt4;
  logic [2*HHW-1:0]       phh [3];
  logic [HHW+HW-1:0]      phl [3];
  logic [2*HW-1:0]        pll [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
    if (en) begin
      q4   <= QW'(sq[0]) + QW'(sq[1]) + QW'(sq[2]);
      obt4 <= obt3;
      for (int i = 0; i < 3; i++) begin
        phh[i] <= nn[i][NW-1:HW] * nn[i][NW-1:HW];
        phl[i] <= nn[i][NW-1:HW] * nn[i][HW-1:0];
        pll[i] <= nn[i][HW-1:0] * nn[i][HW-1:0];
      end
    end
  end

  // stage 5: dividend and divisor of each corner
  logic             deg;
  logic             anyobt;
  logic [N2W-1:0]   nsq [3];

  always_comb begin
    deg    = (q4 == '0);
    anyobt = |obt4;
    for (int i = 0; i < 3; i++) begin
      nsq[i] = (N2W'(phh[i]) << (2 * HW)) + (N2W'(phl[i]) << (HW + 1)) + N2W'(pll[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= v4;
    end
    if (en) begin
      out_flags.degenerate <= deg;
      out_flags.obtuse     <= anyobt && !deg;
      for (int i = 0; i < 3; i++) begin
        if (deg) begin
          num[i] <= '0;
          den[i] <= DEN_W'(1);
        end else if (anyobt) begin
          num[i] <= NUM_W'(q4) << (2 * FRAC_BITS);
          den[i] <= obt4[i] ? DEN_W'(mvca_pkg::OBT_DIV) : DEN_W'(mvca_pkg::SIDE_DIV);
        end else begin
          num[i] <= NUM_W'(nsq[i]) << (2 * FRAC_BITS);
          den[i] <= DEN_W'(q4) << mvca_pkg::ACUTE_SHIFT;
        end
      end
    end
  end

endmodule

// ===== hdl/mvca_div.sv =====
module mvca_div #(
  parameter int NUM_W = 154,
  parameter int DEN_W = 74
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     en,
  input  logic                                     in_vld,
  input  mvca_pkg::flags_t                         in_flags,
  input  logic [2:0][NUM_W-1:0]                    num,
  input  logic [2:0][DEN_W-1:0]                    den,
  output logic                                     out_vld,
  output mvca_pkg::flags_t                         out_flags,
  output logic [2:0][mvca_pkg::QUO_BITS-1:0]       quo
);

  localparam int QB   = mvca_pkg::QUO_BITS;
  localparam int HI_W = (NUM_W > QB) ? NUM_W - QB : 1;
  localparam int XW   = HI_W + QB;

  logic              vld [QB+1];
  mvca_pkg::flags_t  flg [QB+1];
  logic [DEN_W-1:0]  dv  [3][QB+1];
  logic [DEN_W-1:0]  rem [3][QB+1];
  logic [QB-1:0]     sh  [3][QB+1];
  logic              ovf [3][QB+1];

  // entry stage: quotient overflow check and initial remainder
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_vld;
    end
    if (en) begin
      flg[0] <= in_flags;
    end
  end

  for (genvar ln = 0; ln < 3; ln++) begin : g_lane
    logic [XW-1:0]   nx;
    logic [HI_W-1:0] hi;

    assign nx = XW'(num[ln]);
    assign hi = nx[XW-1 -: HI_W];

    always_ff @(posedge clk) begin
      if (en) begin
        dv[ln][0]  <= den[ln];
        ovf[ln][0] <= (hi >= den[ln]);
        rem[ln][0] <= DEN_W'(hi);
        sh[ln][0]  <= nx[QB-1:0];
      end
    end

    // one quotient bit per stage, restoring
    for (genvar k = 0; k < QB; k++) begin : g_step
      logic [DEN_W:0] trial;
      logic [DEN_W:0] diff;

      assign trial = {rem[ln][k], sh[ln][k][QB-1]};
      assign diff  = trial - {1'b0, dv[ln][k]};

      always_ff @(posedge clk) begin
        if (en) begin
          dv[ln][k+1]  <= dv[ln][k];
          ovf[ln][k+1] <= ovf[ln][k];
          if (trial >= {1'b0, dv[ln][k]}) begin
            rem[ln][k+1] <= diff[DEN_W-1:0];
            sh[ln][k+1]  <= {sh[ln][k][QB-2:0], 1'b1};
          end else begin
            rem[ln][k+1] <= trial[DEN_W-1:0];
            sh[ln][k+1]  <= {sh[ln][k][QB-2:0], 1'b0};
          end
        end
      end
    end

    // saturate when the quotient does not fit
    assign quo[ln] = ovf[ln][QB] ? '1 : sh[ln][QB];
  end

  // valid and flags travel with the lanes
  for (genvar k = 0; k < QB; k++) begin : g_ctl
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
      if (en) begin
        flg[k+1] <= flg[k];
      end
    end
  end

  assign out_vld   = vld[QB];
  assign out_flags = flg[QB];

endmodule

// ===== hdl/mvca_sqrt.sv =====
module mvca_sqrt (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    en,
  input  logic                                    in_vld,
  input  mvca_pkg::flags_t                        in_flags,
  input  logic [2:0][mvca_pkg::QUO_BITS-1:0]      rad,
  output logic                                    out_vld,
  output mvca_pkg::flags_t                        out_flags,
  output logic [2:0][mvca_pkg::AREA_BITS-1:0]     root
);

  localparam int RB = mvca_pkg::AREA_BITS;
  localparam int QB = mvca_pkg::QUO_BITS;

  logic              vld [RB+1];
  mvca_pkg::flags_t  flg [RB+1];
  logic [QB-1:0]     rd  [3][RB+1];
  logic [RB:0]       rem [3][RB+1];
  logic [RB-1:0]     rt  [3][RB+1];

  assign vld[0] = in_vld;
  assign flg[0] = in_flags;

  for (genvar ln = 0; ln < 3; ln++) begin : g_lane
    assign rd[ln][0]  = rad[ln];
    assign rem[ln][0] = '0;
    assign rt[ln][0]  = '0;

    // one root bit per stage, restoring
    for (genvar k = 0; k < RB; k++) begin : g_step
      logic [RB+2:0] t;
      logic [RB+2:0] tv;
      logic [RB+2:0] diff;

      assign t    = {rem[ln][k], rd[ln][k][QB-1 -: 2]};
      assign tv   = (RB + 3)'({rt[ln][k], 2'b01});
      assign diff = t - tv;

      always_ff @(posedge clk) begin
        if (en) begin
          rd[ln][k+1] <= rd[ln][k] << 2;
          if (t >= tv) begin
            rem[ln][k+1] <= diff[RB:0];
            rt[ln][k+1]  <= {rt[ln][k][RB-2:0], 1'b1};
          end else begin
            rem[ln][k+1] <= t[RB:0];
            rt[ln][k+1]  <= {rt[ln][k][RB-2:0], 1'b0};
          end
        end
      end
    end

    assign root[ln] = rt[ln][RB];
  end

  for (genvar k = 0; k < RB; k++) begin : g_ctl
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
      if (en) begin
        flg[k+1] <= flg[k];
      end
    end
  end

  assign out_vld   = vld[RB];
  assign out_flags = flg[RB];

endmodule

// ===== hdl/mixed_voronoi_corner_area.sv =====
// pipeline: 5 geometry stages, 85 divider stages, 42 square root stages, output register
// throughput: one triangle per cycle unless stalled; the divider and root stages each resolve one bit
// stalls freeze the whole pipeline once the two-entry output buffer is full
// reset: synchronous active high rst clears all valid bits, no data reset
module mixed_voronoi_corner_area #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // ax, ay, az, bx, by, bz, cx, cy, cz, zero fill
  input  logic [((9*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // area_first, area_second, area_third, zero fill
  output logic [mvca_pkg::OUT_W-1:0]    m_axis_tdata,
  // obtuse_flag, degenerate_flag
  output logic [1:0]                    m_axis_tuser
);

  localparam int NW    = 4 * COORD_BITS + 5;
  localparam int NUM_W = 2 * NW + 2 * FRAC_BITS;
  localparam int DEN_W = 4 * COORD_BITS + 4 + mvca_pkg::ACUTE_SHIFT;
  localparam int AB    = mvca_pkg::AREA_BITS;

  logic                                  en;
  logic [8:0][COORD_BITS-1:0]            coord;
  logic                                  g_vld, d_vld, p_vld;
  mvca_pkg::flags_t                      g_flags, d_flags, p_flags;
  logic [2:0][NUM_W-1:0]                 num;
  logic [2:0][DEN_W-1:0]                 den;
  logic [2:0][mvca_pkg::QUO_BITS-1:0]    quo;
  logic [2:0][AB-1:0]                    root;

  logic                                  out_vld, skid_vld;
  logic [2:0][AB-1:0]                    out_area, skid_area;
  mvca_pkg::flags_t                      out_flags, skid_flags;

  // pipeline moves whenever the skid entry is free
  assign en            = !skid_vld;
  assign s_axis_tready = en;

  for (genvar i = 0; i < 9; i++) begin : g_coord
    assign coord[i] = s_axis_tdata[i*COORD_BITS +: COORD_BITS];
  end

  mvca_geom #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .NUM_W      (NUM_W),
    .DEN_W      (DEN_W)
  ) u_geom (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_vld    (s_axis_tvalid),
    .coord     (coord),
    .out_vld   (g_vld),
    .out_flags (g_flags),
    .num       (num),
    .den       (den)
  );

  mvca_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_vld    (g_vld),
    .in_flags  (g_flags),
    .num       (num),
    .den       (den),
    .out_vld   (d_vld),
    .out_flags (d_flags),
    .quo       (quo)
  );

  mvca_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_vld    (d_vld),
    .in_flags  (d_flags),
    .rad       (quo),
    .out_vld   (p_vld),
    .out_flags (p_flags),
    .root      (root)
  );

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld  <= 1'b0;
      skid_vld <= 1'b0;
    end else if (!out_vld || m_axis_tready) begin
      if (skid_vld) begin
        out_vld  <= 1'b1;
        skid_vld <= 1'b0;
      end else begin
        out_vld <= p_vld;
      end
    end else if (en && p_vld) begin
      skid_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_vld || m_axis_tready) begin
      if (skid_vld) begin
        out_area  <= skid_area;
        out_flags <= skid_flags;
      end else begin
        out_area  <= root;
        out_flags <= p_flags;
      end
    end else if (en) begin
      skid_area  <= root;
      skid_flags <= p_flags;
    end
  end

  assign m_axis_tvalid = out_vld;
  assign m_axis_tdata  = mvca_pkg::OUT_W'(out_area);
  assign m_axis_tuser  = {out_flags.degenerate, out_flags.obtuse};

endmodule

// ===== hdl/mvca_check.sv =====
module mvca_check (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_axis_tready,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [mvca_pkg::OUT_W-1:0]  m_axis_tdata,
  input logic [1:0]                  m_axis_tuser
);

  localparam int AW3 = 3 * mvca_pkg::AREA_BITS;

  // no result beat right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result beat right after reset");

  // a stalled result beat holds its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result beat changed");

  // input back-pressure only when a result is waiting
  a_bp: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no result pending");

  // degenerate triangle gives zero areas and no obtuse mark
  a_degen: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata[AW3-1:0] == '0 && !m_axis_tuser[0])
    else $error("degenerate triangle with nonzero result");

endmodule

bind mixed_voronoi_corner_area mvca_check u_check (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 8;
  localparam int IN_W       = ((9 * COORD_BITS + 7) / 8) * 8;

  typedef logic [255:0] wide_t;
  typedef logic [mvca_pkg::AREA_BITS-1:0] area_t;

  typedef struct {
    area_t             area[3];
    mvca_pkg::flags_t  flags;
  } corner_areas_t;

  // exact corner area prediction and in-order comparison
  class area_scoreboard;
    corner_areas_t pending[$];
    int errors;

    // largest r below 2^AREA_BITS with r*r*a <= b
    function area_t floor_root(wide_t a, wide_t b);
      area_t r;
      area_t c;
      r = '0;
      for (int bit_i = mvca_pkg::AREA_BITS - 1; bit_i >= 0; bit_i--) begin
        c = r | (area_t'(1) << bit_i);
        if (wide_t'(c) * wide_t'(c) * a <= b) r = c;
      end
      return r;
    endfunction

    function void note_triangle(int p[9]);
      corner_areas_t e;
      longint ab[3], ac[3], bc[3], cr[3], dt[3];
      longint lab, lbc, lca;
      longint e1[3], e2[3], o1[3], o2[3];
      wide_t q, n;
      for (int i = 0; i < 3; i++) begin
        ab[i] = p[3 + i] - p[i];
        ac[i] = p[6 + i] - p[i];
        bc[i] = p[6 + i] - p[3 + i];
      end
      cr[0] = ab[1] * ac[2] - ab[2] * ac[1];
      cr[1] = ab[2] * ac[0] - ab[0] * ac[2];
      cr[2] = ab[0] * ac[1] - ab[1] * ac[0];
      q = '0;
      for (int i = 0; i < 3; i++) begin
        n = wide_t'(cr[i] < 0 ? -cr[i] : cr[i]);
        q = q + n * n;
      end
      e.area = '{default: '0};
      e.flags = '0;
      if (q == 0) begin
        e.flags.degenerate = 1'b1;
        pending.push_back(e);
        return;
      end
      dt[0] = ab[0] * ac[0] + ab[1] * ac[1] + ab[2] * ac[2];
      dt[1] = -(ab[0] * bc[0] + ab[1] * bc[1] + ab[2] * bc[2]);
      dt[2] = ac[0] * bc[0] + ac[1] * bc[1] + ac[2] * bc[2];
      lab = ab[0] * ab[0] + ab[1] * ab[1] + ab[2] * ab[2];
      lbc = bc[0] * bc[0] + bc[1] * bc[1] + bc[2] * bc[2];
      lca = ac[0] * ac[0] + ac[1] * ac[1] + ac[2] * ac[2];
      if (dt[0] < 0 || dt[1] < 0 || dt[2] < 0) begin
        // obtuse corner takes half the area, the others a quarter
        e.flags.obtuse = 1'b1;
        for (int k = 0; k < 3; k++)
          e.area[k] = floor_root(dt[k] < 0 ? mvca_pkg::OBT_DIV : mvca_pkg::SIDE_DIV,
                                 q << (2 * FRAC_BITS));
      end else begin
        e1 = '{lab, lab, lca}; o1 = '{dt[2], dt[2], dt[1]};
        e2 = '{lca, lbc, lbc}; o2 = '{dt[1], dt[0], dt[0]};
        for (int k = 0; k < 3; k++) begin
          n = wide_t'(e1[k]) * wide_t'(o1[k]) + wide_t'(e2[k]) * wide_t'(o2[k]);
          e.area[k] = floor_root(q << mvca_pkg::ACUTE_SHIFT, (n * n) << (2 * FRAC_BITS));
        end
      end
      pending.push_back(e);
    endfunction

    function void check_result(logic [mvca_pkg::OUT_W-1:0] data, logic [1:0] user);
      corner_areas_t e;
      area_t got;
      mvca_pkg::flags_t fl;
      string names[3];
      names = '{"area_first", "area_second", "area_third"};
      if (pending.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
        return;
      end
      e = pending.pop_front();
      fl = user;
      for (int k = 0; k < 3; k++) begin
        got = data[k * mvca_pkg::AREA_BITS +: mvca_pkg::AREA_BITS];
        if (got !== e.area[k]) begin
          $error("%s expected %0d actual %0d", names[k], e.area[k], got);
          errors++;
        end
      end
      if (fl.obtuse !== e.flags.obtuse) begin
        $error("obtuse_flag expected %0b actual %0b", e.flags.obtuse, fl.obtuse);
        errors++;
      end
      if (fl.degenerate !== e.flags.degenerate) begin
        $error("degenerate_flag expected %0b actual %0b", e.flags.degenerate, fl.degenerate);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [mvca_pkg::OUT_W-1:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;

  area_scoreboard areas = new();
  int burst_left = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  mixed_voronoi_corner_area #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) uut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  // receiver stall pattern: long open stretches, then bursts of stalls
  always @(negedge clk) begin
    int ph;
    ph = $urandom_range(0, 99);
    if (rst) m_axis_tready <= 1'b0;
    else if (ph < 8) m_axis_tready <= 1'b0;
    else if (ph < 12) m_axis_tready <= ~m_axis_tready;
    else if (ph < 70) m_axis_tready <= 1'b1;
  end

  always @(posedge clk)
    if (!rst && m_axis_tvalid && m_axis_tready) areas.check_result(m_axis_tdata, m_axis_tuser);

  // drive one triangle beat and wait for it to be taken
  task automatic send_triangle(int p[9]);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    for (int i = 0; i < 9; i++) s_axis_tdata[i * COORD_BITS +: COORD_BITS] = p[i][15:0];
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    areas.note_triangle(p);
    @(negedge clk);
  endtask

  function automatic int rnd_coord(int lo, int hi);
    return $urandom_range(0, hi - lo) + lo;
  endfunction

  initial begin
    int p[9];
    int kind, s, base, k;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: degenerate, extremes, right angle, obtuse at each corner
    send_triangle('{0, 0, 0, 0, 0, 0, 0, 0, 0});
    send_triangle('{1, 2, 3, 1, 2, 3, 5, 5, 5});
    send_triangle('{0, 0, 0, 1, 1, 1, 2, 2, 2});
    send_triangle('{-32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767, 32767});
    send_triangle('{32767, 32767, 32767, -32768, 32767, 32767, 32767, -32768, -32768});
    send_triangle('{-32768, -32768, 0, 32767, -32768, 0, -32768, 32767, 0});
    send_triangle('{32767, 0, -32768, -32768, 32767, 0, 0, -32768, 32767});
    send_triangle('{0, 0, 0, 4, 0, 0, 0, 3, 0});
    send_triangle('{0, 0, 0, 2, 0, 0, 1, 1, 0});
    send_triangle('{0, 0, 0, 10, 0, 0, -5, 1, 0});
    send_triangle('{-5, 1, 0, 0, 0, 0, 10, 0, 0});
    send_triangle('{10, 0, 0, -5, 1, 0, 0, 0, 0});
    send_triangle('{0, 0, 0, 2, 0, 0, 1, 2, 0});
    send_triangle('{1, 0, 0, 0, 1, 0, 0, 0, 1});
    send_triangle('{-32768, 32767, -1, -32768, 32767, 0, -32767, 32767, -1});
    send_triangle('{-32768, 0, 0, 32767, 0, 0, 0, 1, 0});

    // random triangles of several shapes
    for (int n = 0; n < 1100; n++) begin
      kind = $urandom_range(0, 9);
      if (kind < 3) begin
        foreach (p[i]) p[i] = rnd_coord(-32768, 32767);
      end else if (kind < 7) begin
        s = (kind == 6) ? 32 : 2000;
        for (int i = 0; i < 3; i++) begin
          base = rnd_coord(-30000, 30000);
          for (int v = 0; v < 3; v++) p[v * 3 + i] = base + rnd_coord(-s, s);
        end
      end else if (kind == 7) begin
        // collinear: c on the line through a and b
        k = rnd_coord(-3, 3);
        for (int i = 0; i < 3; i++) begin
          p[i] = rnd_coord(-1000, 1000);
          p[3 + i] = p[i] + rnd_coord(-1000, 1000);
          p[6 + i] = p[i] + k * (p[3 + i] - p[i]);
        end
      end else if (kind == 8) begin
        // right angle at corner a or b in a random plane offset
        base = rnd_coord(-20000, 20000);
        s = $urandom_range(1, 5000);
        k = $urandom_range(1, 5000);
        p = '{base, base, base, base + s, base, base, base, base + k, base};
        if ($urandom_range(0, 1)) begin
          for (int i = 0; i < 3; i++) begin
            int t;
            t = p[i]; p[i] = p[3 + i]; p[3 + i] = t;
          end
        end
      end else begin
        // duplicate corner
        foreach (p[i]) p[i] = rnd_coord(-32768, 32767);
        k = $urandom_range(0, 2);
        for (int i = 0; i < 3; i++) p[((k + 1) % 3) * 3 + i] = p[k * 3 + i];
      end
      send_triangle(p);
    end
    s_axis_tvalid = 1'b0;

    while (areas.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (areas.errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #1000000;
    $display("simulation failed");
    $finish;
  end

endmodule
